// ----- src/col_pkg.sv -----
// Shared types and constants for the compacting ordered list.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package col_pkg;

    localparam int OPCODE_W      = 3;
    localparam int POS_W         = 6;
    localparam int VALUE_W       = 64;
    localparam int COUNT_OUT_W   = 7;
    localparam int DEFAULT_DEPTH = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_SET    = 3'd1,
        OP_GET    = 3'd2,
        OP_DELETE = 3'd3,
        OP_COUNT  = 3'd4
    } col_op_t;

    // One-cycle strobes broadcast from the controller to every cell.
    typedef struct packed {
        logic app;
        logic set;
        logic get;
        logic del;
    } col_cmd_t;

endpackage

`default_nettype wire

// ----- src/col_req_if.sv -----
// Request channel of the compacting ordered list: valid, ready and the input word.
// Depends on col_pkg for the field widths.
`default_nettype none

interface col_req_if;
    logic                          valid;
    logic                          ready;
    logic [col_pkg::OPCODE_W-1:0]  opcode;
    logic [col_pkg::POS_W-1:0]     position;
    logic [col_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- src/col_rsp_if.sv -----
// Response channel of the compacting ordered list: valid, ready and the result word.
// Depends on col_pkg for the field widths.
`default_nettype none

interface col_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic [col_pkg::VALUE_W-1:0]      read_value;
    logic [col_pkg::COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, output ok, output read_value, output entry_count, input ready);
    modport sink   (input valid, input ok, input read_value, input entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/col_cell.sv -----
// One storage cell of the list: holds a single entry and one stage of the read chain.
// Depends on col_pkg; instantiated in a row by compacting_ordered_list.
`default_nettype none

module col_cell #(
    parameter int CMPW  = 7,
    parameter int INDEX = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire col_pkg::col_cmd_t           cmd,
    input  wire logic [CMPW-1:0]             pos,
    input  wire logic [CMPW-1:0]             count,
    input  wire logic [col_pkg::VALUE_W-1:0] value,
    input  wire logic [col_pkg::VALUE_W-1:0] upper_entry,
    input  wire logic [col_pkg::VALUE_W-1:0] upper_rd_data,
    input  wire logic                        upper_rd_valid,
    output logic [col_pkg::VALUE_W-1:0]      entry,
    output logic [col_pkg::VALUE_W-1:0]      rd_data,
    output logic                             rd_valid
);

    localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

    logic [col_pkg::VALUE_W-1:0] entry_reg, entry_next;
    logic [col_pkg::VALUE_W-1:0] rd_data_reg, rd_data_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        hit_pos;

    assign hit_pos = (IDX == pos);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.del && (IDX >= pos))
        begin
            // Everything at or above the deleted slot moves down by one.
            entry_next = upper_entry;
        end
        else if (cmd.set && hit_pos)
        begin
            entry_next = value;
        end
        else if (cmd.app && (IDX == count))
        begin
            entry_next = value;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // The read chain moves toward cell zero; the addressed cell injects its entry.
    always_comb
    begin
        rd_valid_next = upper_rd_valid || (cmd.get && hit_pos);
        rd_data_next  = (cmd.get && hit_pos) ? entry_reg : upper_rd_data;
    end

    always_ff @(posedge clk)
    begin
        entry_reg   <= entry_next;
        rd_data_reg <= rd_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign entry    = entry_reg;
    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ----- src/compacting_ordered_list.sv -----
// Top level of the compacting ordered list: controller, fill count and the row of cells.
// Depends on col_pkg, col_req_if, col_rsp_if and col_cell.
`default_nettype none

// The block keeps an ordered list of up to DEPTH 64-bit words in a row of cells, one word
// per cell, together with a fill count. Each request word carries an opcode: append adds a
// word at the end (fails when full), set overwrites an entry below the count, get reads an
// entry below the count, delete removes an entry and closes the gap, and count only reports.
// Every request produces exactly one response word with ok, read_value (nonzero only for a
// successful get) and entry_count, the low seven bits of the count after the operation.
// Requests are handled one at a time: a request is taken while the block is idle, and the
// next one only after its response has been taken. Append, set, delete, count and any
// failing request present their response in the cycle after acceptance, since every cell
// updates in parallel on the accepting edge (delete shifts all higher cells down at once). A
// successful get at index p travels down the read chain of the cells, one cell per cycle,
// and its response appears once the word has left cell zero. The list storage needs no
// clearing after reset; only the fill count, state and read-chain valid bits are reset.

module compacting_ordered_list #(
    parameter int DEPTH = col_pkg::DEFAULT_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    col_req_if.sink    req,
    col_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMPW  = (CNT_W > col_pkg::POS_W) ? CNT_W : col_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            ok_reg;
    logic [col_pkg::VALUE_W-1:0]     rdv_reg;
    logic [col_pkg::COUNT_OUT_W-1:0] cnt_out_reg;

    logic                                  accept;
    logic                                  op_ok;
    logic                                  in_range;
    logic                                  not_full;
    logic [CMPW-1:0]                       pos_ext;
    logic [CMPW-1:0]                       cnt_ext;
    logic [CNT_W+col_pkg::COUNT_OUT_W-1:0] cnt_wide;
    col_pkg::col_cmd_t                     cmd;

    // Cell row wiring.
    logic [col_pkg::VALUE_W-1:0] ent     [DEPTH];
    logic [col_pkg::VALUE_W-1:0] rd_data [DEPTH];
    logic [DEPTH-1:0]            rd_valid;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign pos_ext  = CMPW'(req.position);
    assign cnt_ext  = CMPW'(count_reg);
    assign in_range = (pos_ext < cnt_ext);
    assign not_full = (count_reg < CNT_W'(DEPTH));

    // Decode the request; cell strobes fire only on the accepting edge.
    always_comb
    begin
        cmd        = '0;
        op_ok      = 1'b0;
        count_next = count_reg;
        unique case (col_pkg::col_op_t'(req.opcode))
            col_pkg::OP_APPEND:
            begin
                if (not_full)
                begin
                    cmd.app    = accept;
                    op_ok      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            col_pkg::OP_SET:
            begin
                if (in_range)
                begin
                    cmd.set = accept;
                    op_ok   = 1'b1;
                end
            end
            col_pkg::OP_GET:
            begin
                if (in_range)
                begin
                    cmd.get = accept;
                    op_ok   = 1'b1;
                end
            end
            col_pkg::OP_DELETE:
            begin
                if (in_range)
                begin
                    cmd.del    = accept;
                    op_ok      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            col_pkg::OP_COUNT:
            begin
                op_ok = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // entry_count reports the low bits of the count, zero-extended for small lists.
    assign cnt_wide = {{col_pkg::COUNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cmd.get ? S_READ : S_SEND;
                end
            end
            S_READ:
            begin
                if (rd_valid[0])
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Response payload; a get fills read_value when the word leaves cell zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg      <= op_ok;
            rdv_reg     <= '0;
            cnt_out_reg <= cnt_wide[col_pkg::COUNT_OUT_W-1:0];
        end
        else if ((state_reg == S_READ) && rd_valid[0])
        begin
            rdv_reg <= rd_data[0];
        end
    end

    assign rsp.valid       = (state_reg == S_SEND);
    assign rsp.ok          = ok_reg;
    assign rsp.read_value  = rdv_reg;
    assign rsp.entry_count = cnt_out_reg;

    // The row of cells. The top cell has no upper neighbor: it keeps its own word on a
    // delete and feeds an empty read chain.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [col_pkg::VALUE_W-1:0] up_entry;
        logic [col_pkg::VALUE_W-1:0] up_rd_data;
        logic                        up_rd_valid;

        if (i == DEPTH - 1)
        begin : g_top
            assign up_entry    = ent[i];
            assign up_rd_data  = '0;
            assign up_rd_valid = 1'b0;
        end
        else
        begin : g_mid
            assign up_entry    = ent[i+1];
            assign up_rd_data  = rd_data[i+1];
            assign up_rd_valid = rd_valid[i+1];
        end

        col_cell #(
            .CMPW  (CMPW),
            .INDEX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .pos            (pos_ext),
            .count          (cnt_ext),
            .value          (req.value),
            .upper_entry    (up_entry),
            .upper_rd_data  (up_rd_data),
            .upper_rd_valid (up_rd_valid),
            .entry          (ent[i]),
            .rd_data        (rd_data[i]),
            .rd_valid       (rd_valid[i])
        );
    end

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // Only one read travels the chain, and only while a get is outstanding.
    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rd_valid) && ((rd_valid == '0) || (state_reg == S_READ)))
        else $error("stray or multiple reads in the cell chain");

    // A delete lowers the count by exactly one.
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.del) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not lower the count by one");

    // An append raises the count by exactly one.
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.app) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not raise the count by one");

endmodule

`default_nettype wire
